/* design/tlb_page_table_translator_top_assert.svh */
// Assertion macros used by the address translator controller (tpt_ctrl).
// Needs clk_i and rst_ni in the scope of each use.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_TOP_ASSERT_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_TOP_ASSERT_SVH

// same-cycle implication
`define TPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/tpt_pkg.sv */
// Types and constants of the paged address translator.
// No dependencies.
`timescale 1ns / 1ps
package tpt_pkg;
  localparam int NUM_PAGES   = 256;
  localparam int PAGE_W      = 8;
  localparam int NUM_FRAMES  = 128;
  localparam int FRAME_W     = 7;
  localparam int USED_W      = 8;
  localparam int TLB_ENTRIES = 16;
  localparam int TLB_W       = 4;
  localparam int OFFSET_W    = 8;
  localparam int VA_W        = 16;
  localparam int PA_W        = 15;
  localparam int CLOCK_W     = 32;
  localparam int CNT_W       = 16;

  localparam logic CFG_FRAME_POLICY = 1'b0;
  localparam logic CFG_TLB_POLICY   = 1'b1;
  localparam logic POLICY_FIFO      = 1'b0;
  localparam logic POLICY_LRU       = 1'b1;

  typedef struct packed {
    logic load_va;
    logic hit_upd;
    logic pt_got;
    logic fault_upd;
    logic take_free;
    logic take_fifo;
    logic scan_clr;
    logic scan_step;
    logic own_rd;
    logic old_rd;
    logic evict;
    logic assign_frame;
    logic tlb_sel;
    logic tlb_scan_step;
    logic tlb_wr;
    logic finish;
  } tpt_cmd_t;

  typedef struct packed {
    logic tlb_hit;
    logic page_resident;
    logic frames_full;
    logic frame_lru;
    logic tlb_free;
    logic tlb_lru;
    logic scan_last;
    logic tlb_scan_last;
  } tpt_status_t;
endpackage

/* design/tpt_datapath.sv */
// Datapath of the translator: TLB, page table memories, counters and policies.
// Depends on tpt_pkg; driven by tpt_ctrl.
`timescale 1ns / 1ps
module tpt_datapath import tpt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tpt_cmd_t            cmd_i,
  output tpt_status_t         status_o,
  input  logic [VA_W-1:0]     virtual_address_i,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic                cfg_data_i,
  output logic [PA_W-1:0]     physical_address_o,
  output logic                tlb_hit_o,
  output logic                page_fault_o,
  output logic [PAGE_W-1:0]   load_page_o,
  output logic [CNT_W-1:0]    fault_total_o,
  output logic [CNT_W-1:0]    hit_total_o
);
  logic                  frame_policy_q, tlb_policy_q;
  logic [VA_W-1:0]       va_q;
  logic [PAGE_W-1:0]     page;
  logic [FRAME_W-1:0]    frame_q, victim_q;
  logic                  hit_q, fault_q;
  logic [CNT_W-1:0]      fault_cnt_q, hit_cnt_q;
  logic [CLOCK_W-1:0]    use_clock_q, best_age_q, tlb_best_q;
  logic [USED_W-1:0]     frames_used_q;
  logic [FRAME_W-1:0]    frame_ptr_q;
  logic [TLB_W-1:0]      tlb_ptr_q, slot_q, tidx_q;
  logic [PAGE_W-1:0]     scan_idx_q;
  logic                  scan_pend_q, scan_vld_q, found_q;

  logic [NUM_PAGES-1:0]  page_valid_q;
  logic [FRAME_W-1:0]    page_frame_mem [NUM_PAGES];
  logic [CLOCK_W-1:0]    page_use_mem [NUM_PAGES];
  logic [PAGE_W-1:0]     owner_mem [NUM_FRAMES];
  logic [FRAME_W-1:0]    pf_rdata_q;
  logic [CLOCK_W-1:0]    plu_rdata_q;
  logic [PAGE_W-1:0]     own_rdata_q;

  logic [TLB_ENTRIES-1:0] tlb_valid_q;
  logic [PAGE_W-1:0]      tlb_tag_q [TLB_ENTRIES];
  logic [FRAME_W-1:0]     tlb_frame_q [TLB_ENTRIES];
  logic [CLOCK_W-1:0]     tlb_use_q [TLB_ENTRIES];

  logic [PAGE_W-1:0]     pt_addr;
  logic                  plu_we;
  logic                  hit_any, free_any;
  logic [TLB_W-1:0]      hit_idx, free_idx;
  logic [CLOCK_W-1:0]    scan_age, tlb_age;

  assign page = va_q[VA_W-1:OFFSET_W];

  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid_q[i] && tlb_tag_q[i] == page) begin
        hit_any = 1'b1;
        hit_idx = TLB_W'(i);
      end
      if (!tlb_valid_q[i]) begin
        free_any = 1'b1;
        free_idx = TLB_W'(i);
      end
    end
  end

  assign status_o.tlb_hit       = hit_any;
  assign status_o.page_resident = page_valid_q[page];
  assign status_o.frames_full   = (frames_used_q == USED_W'(NUM_FRAMES));
  assign status_o.frame_lru     = (frame_policy_q == POLICY_LRU);
  assign status_o.tlb_free      = free_any;
  assign status_o.tlb_lru       = (tlb_policy_q == POLICY_LRU);
  assign status_o.scan_last     = &scan_idx_q;
  assign status_o.tlb_scan_last = &tidx_q;

  always_comb begin
    if (cmd_i.old_rd) begin
      pt_addr = own_rdata_q;
    end else if (cmd_i.scan_step) begin
      pt_addr = scan_idx_q;
    end else begin
      pt_addr = page;
    end
  end
  assign plu_we   = cmd_i.hit_upd | cmd_i.pt_got | cmd_i.assign_frame;
  assign scan_age = use_clock_q - plu_rdata_q;
  assign tlb_age  = use_clock_q - tlb_use_q[tidx_q];

  always_ff @(posedge clk_i) begin
    if (cmd_i.assign_frame) begin
      page_frame_mem[page] <= victim_q;
      owner_mem[victim_q]  <= page;
    end
    if (plu_we) begin
      page_use_mem[page] <= use_clock_q;
    end
    pf_rdata_q  <= page_frame_mem[pt_addr];
    plu_rdata_q <= page_use_mem[pt_addr];
    if (cmd_i.own_rd) begin
      own_rdata_q <= owner_mem[victim_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_valid_q <= '0;
    end else begin
      if (cmd_i.evict && page_valid_q[own_rdata_q] && pf_rdata_q == victim_q) begin
        page_valid_q[own_rdata_q] <= 1'b0;
      end
      if (cmd_i.assign_frame) begin
        page_valid_q[page] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlb_valid_q <= '0;
    end else begin
      if (cmd_i.evict) begin
        for (int i = 0; i < TLB_ENTRIES; i++) begin
          if (tlb_frame_q[i] == victim_q) begin
            tlb_valid_q[i] <= 1'b0;
          end
        end
      end
      if (cmd_i.tlb_wr) begin
        tlb_valid_q[slot_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hit_upd) begin
      tlb_use_q[hit_idx] <= use_clock_q;
    end
    if (cmd_i.tlb_wr) begin
      tlb_tag_q[slot_q]   <= page;
      tlb_frame_q[slot_q] <= frame_q;
      tlb_use_q[slot_q]   <= use_clock_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_va) begin
      va_q <= virtual_address_i;
    end
    if (cmd_i.hit_upd) begin
      frame_q <= tlb_frame_q[hit_idx];
    end else if (cmd_i.pt_got) begin
      frame_q <= pf_rdata_q;
    end else if (cmd_i.assign_frame) begin
      frame_q <= victim_q;
    end
    if (cmd_i.take_free) begin
      victim_q <= frames_used_q[FRAME_W-1:0];
    end else if (cmd_i.take_fifo) begin
      victim_q <= frame_ptr_q;
    end else if (scan_pend_q && scan_vld_q && (!found_q || scan_age > best_age_q)) begin
      victim_q <= pf_rdata_q;
    end
    if (scan_pend_q && scan_vld_q && (!found_q || scan_age > best_age_q)) begin
      best_age_q <= scan_age;
    end
    scan_vld_q <= page_valid_q[scan_idx_q];
    if (cmd_i.tlb_sel) begin
      if (free_any) begin
        slot_q <= free_idx;
      end else if (tlb_policy_q == POLICY_FIFO) begin
        slot_q <= tlb_ptr_q;
      end
      tidx_q <= '0;
    end else if (cmd_i.tlb_scan_step) begin
      if (tidx_q == '0 || tlb_age > tlb_best_q) begin
        tlb_best_q <= tlb_age;
        slot_q     <= tidx_q;
      end
      tidx_q <= tidx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_policy_q <= POLICY_FIFO;
      tlb_policy_q   <= POLICY_FIFO;
      hit_q          <= 1'b0;
      fault_q        <= 1'b0;
      fault_cnt_q    <= '0;
      hit_cnt_q      <= '0;
      use_clock_q    <= '0;
      frames_used_q  <= '0;
      frame_ptr_q    <= '0;
      tlb_ptr_q      <= '0;
      scan_idx_q     <= '0;
      scan_pend_q    <= 1'b0;
      found_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_FRAME_POLICY: frame_policy_q <= cfg_data_i;
          CFG_TLB_POLICY:   tlb_policy_q   <= cfg_data_i;
          default:          ;
        endcase
      end
      if (cmd_i.load_va) begin
        hit_q   <= 1'b0;
        fault_q <= 1'b0;
      end
      if (cmd_i.hit_upd) begin
        hit_q <= 1'b1;
        if (~&hit_cnt_q) begin
          hit_cnt_q <= hit_cnt_q + 1'b1;
        end
      end
      if (cmd_i.fault_upd) begin
        fault_q <= 1'b1;
        if (~&fault_cnt_q) begin
          fault_cnt_q <= fault_cnt_q + 1'b1;
        end
      end
      if (cmd_i.take_free) begin
        frames_used_q <= frames_used_q + 1'b1;
      end
      if (cmd_i.take_fifo) begin
        frame_ptr_q <= frame_ptr_q + 1'b1;
      end
      if (cmd_i.tlb_sel && !free_any && tlb_policy_q == POLICY_FIFO) begin
        tlb_ptr_q <= tlb_ptr_q + 1'b1;
      end
      scan_pend_q <= cmd_i.scan_step;
      if (cmd_i.scan_clr) begin
        scan_idx_q <= '0;
        found_q    <= 1'b0;
      end else begin
        if (cmd_i.scan_step) begin
          scan_idx_q <= scan_idx_q + 1'b1;
        end
        if (scan_pend_q && scan_vld_q) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        use_clock_q <= use_clock_q + 1'b1;
      end
    end
  end

  assign physical_address_o = {frame_q, va_q[OFFSET_W-1:0]};
  assign tlb_hit_o          = hit_q;
  assign page_fault_o       = fault_q;
  assign load_page_o        = fault_q ? page : '0;
  assign fault_total_o      = fault_cnt_q;
  assign hit_total_o        = hit_cnt_q;
endmodule

/* design/tpt_ctrl.sv */
// Controller of the translator: sequences lookup, fault handling and TLB fill.
// Depends on tpt_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "tlb_page_table_translator_top_assert.svh"
module tpt_ctrl import tpt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  output logic        done_o,
  input  tpt_status_t status_i,
  output tpt_cmd_t    cmd_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_PTGOT, S_TAKE, S_SCAN, S_SCANW, S_OWNRD, S_OLDRD,
    S_EVICT, S_ASSIGN, S_TLBSEL, S_TLBSCAN, S_TLBWR, S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_va = 1'b1;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (status_i.tlb_hit) begin
          cmd_o.hit_upd = 1'b1;
          state_d = S_OUT;
        end else if (status_i.page_resident) begin
          state_d = S_PTGOT;
        end else begin
          cmd_o.fault_upd = 1'b1;
          state_d = S_TAKE;
        end
      end
      S_PTGOT: begin
        cmd_o.pt_got = 1'b1;
        state_d = S_TLBSEL;
      end
      S_TAKE: begin
        if (!status_i.frames_full) begin
          cmd_o.take_free = 1'b1;
          state_d = S_ASSIGN;
        end else if (!status_i.frame_lru) begin
          cmd_o.take_fifo = 1'b1;
          state_d = S_OWNRD;
        end else begin
          cmd_o.scan_clr = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = S_SCANW;
        end
      end
      S_SCANW: state_d = S_OWNRD;
      S_OWNRD: begin
        cmd_o.own_rd = 1'b1;
        state_d = S_OLDRD;
      end
      S_OLDRD: begin
        cmd_o.old_rd = 1'b1;
        state_d = S_EVICT;
      end
      S_EVICT: begin
        cmd_o.evict = 1'b1;
        state_d = S_ASSIGN;
      end
      S_ASSIGN: begin
        cmd_o.assign_frame = 1'b1;
        state_d = S_TLBSEL;
      end
      S_TLBSEL: begin
        cmd_o.tlb_sel = 1'b1;
        if (status_i.tlb_free || !status_i.tlb_lru) begin
          state_d = S_TLBWR;
        end else begin
          state_d = S_TLBSCAN;
        end
      end
      S_TLBSCAN: begin
        cmd_o.tlb_scan_step = 1'b1;
        if (status_i.tlb_scan_last) begin
          state_d = S_TLBWR;
        end
      end
      S_TLBWR: begin
        cmd_o.tlb_wr = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        cmd_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_d == S_OUT);
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  `TPT_ASSERT_NEXT(a_done_single, done_q, !done_q, "result strobe longer than one cycle")
  `TPT_ASSERT_NOW(a_done_state, done_q, state_q == S_OUT, "result strobe outside output state")
  `TPT_ASSERT_NEXT(a_accept_look, start_i && !busy_o, state_q == S_LOOK, "accepted word not looked up")
  `TPT_ASSERT_NOW(a_idle_quiet, !busy_o, !done_q, "result strobe while idle")
endmodule

/* design/tlb_page_table_translator_top.sv */
// Address translator with TLB and page table, FIFO or LRU replacement.
// Usage:
//   Raise start_i with virtual_address_i while busy_o is low; the word is
//   taken at that edge and busy_o stays high until the result is out.
//   done_o is high for exactly one cycle with physical_address_o, tlb_hit_o,
//   page_fault_o, load_page_o, fault_total_o and hit_total_o; take it then,
//   the block holds it only until the next start and the receiver cannot stall it.
//   Configuration: cfg_valid_i with cfg_index_i (0 frame policy, 1 TLB
//   policy) and cfg_data_i; cfg_ready_o is always high. Write only when idle.
// Paths from start to done:
//   TLB hit; page-table hit; fault with a free frame or FIFO victim; fault
//   with an LRU frame victim (scan of all 256 page entries through the page
//   table read port), plus a scan of all 16 TLB entries for an LRU TLB victim.
//   One word at a time, next start the cycle after done.
// Reset clears valid bits, pointers, counters and policies; no sweep needed.
`timescale 1ns / 1ps
module tlb_page_table_translator_top import tpt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [VA_W-1:0]     virtual_address_i,
  output logic                done_o,
  output logic [PA_W-1:0]     physical_address_o,
  output logic                tlb_hit_o,
  output logic                page_fault_o,
  output logic [PAGE_W-1:0]   load_page_o,
  output logic [CNT_W-1:0]    fault_total_o,
  output logic [CNT_W-1:0]    hit_total_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic                cfg_data_i
);
  tpt_cmd_t    cmd;
  tpt_status_t status;
  logic        busy;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = busy;

  tpt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy),
    .done_o   (done_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  tpt_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .virtual_address_i  (virtual_address_i),
    .cfg_we_i           (cfg_valid_i & cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .physical_address_o (physical_address_o),
    .tlb_hit_o          (tlb_hit_o),
    .page_fault_o       (page_fault_o),
    .load_page_o        (load_page_o),
    .fault_total_o      (fault_total_o),
    .hit_total_o        (hit_total_o)
  );
endmodule
